// ===== hw/rtl/spa_pkg.sv =====
// ----------------------------------------------------------------------------
// spa_pkg - shared definitions of the sparse polynomial adder
// Operation codes, default sizes, and the command and status bundles that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package spa_pkg;

  // Default sizes
  localparam int unsigned MaxTermsDef = 16;
  localparam int unsigned ExpBitsDef  = 8;
  localparam int unsigned CoefBitsDef = 16;

  // Operation carried in the input tuser
  typedef enum logic [1:0] {
    OP_LOAD_A = 2'd0,
    OP_LOAD_B = 2'd1,
    OP_EMIT   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  // Controller states, one-hot
  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SEARCH = 4'b0010,
    ST_INSERT = 4'b0100,
    ST_MERGE  = 4'b1000
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;      // latch the input transaction, rewind the read indexes
    logic clear;        // empty both stores
    logic search_step;  // advance the read index of the selected store
    logic insert;       // combine or insert the latched term at the read index
    logic merge_emit;   // register the next sum term, advance the indexes
    logic empty_emit;   // register the empty-sum result
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic search_done;  // insert position found in the selected store
    logic merge_last;   // the merge step in hand gives the final term
    logic sum_empty;    // both stores hold no term
    logic out_free;     // output register may be loaded this cycle
  } sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/spa_store.sv =====
// ----------------------------------------------------------------------------
// spa_store - one sorted term store
// Holds up to MAX_TERMS terms in descending exponent order with a fill
// count. Reads one entry at a given index; at that index combines an equal
// exponent with saturation, or shifts the tail down one place and inserts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spa_store #(
  parameter int unsigned MAX_TERMS = spa_pkg::MaxTermsDef,
  parameter int unsigned EXP_BITS  = spa_pkg::ExpBitsDef,
  parameter int unsigned COEF_BITS = spa_pkg::CoefBitsDef,
  localparam int unsigned CNT_W    = $clog2(MAX_TERMS + 1)
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        clear,
  input  wire logic                        insert,
  input  wire logic [EXP_BITS-1:0]         ex,
  input  wire logic signed [COEF_BITS-1:0] co,
  input  wire logic [CNT_W-1:0]            rd_idx,
  output logic [EXP_BITS-1:0]              rd_ex,
  output logic signed [COEF_BITS-1:0]      rd_co,
  output logic [CNT_W-1:0]                 cnt
);

  localparam int unsigned IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam logic signed [COEF_BITS-1:0] CoefMax = {1'b0, {(COEF_BITS-1){1'b1}}};
  localparam logic signed [COEF_BITS-1:0] CoefMin = {1'b1, {(COEF_BITS-1){1'b0}}};

  logic [EXP_BITS-1:0]         ex_m [MAX_TERMS];
  logic signed [COEF_BITS-1:0] co_m [MAX_TERMS];
  logic [EXP_BITS-1:0]         sh_ex [MAX_TERMS];
  logic signed [COEF_BITS-1:0] sh_co [MAX_TERMS];
  logic                        pos_ok;
  logic                        hit;
  logic                        full;
  logic signed [COEF_BITS:0]   sum_w;
  logic signed [COEF_BITS-1:0] sat;

  // Read the entry at the index
  assign rd_ex = ex_m[rd_idx[IDX_W-1:0]];
  assign rd_co = co_m[rd_idx[IDX_W-1:0]];

  assign pos_ok = (rd_idx < cnt);
  assign hit    = pos_ok && (rd_ex == ex);
  assign full   = (cnt == CNT_W'(MAX_TERMS));

  // Saturating add for an equal exponent
  assign sum_w = {rd_co[COEF_BITS-1], rd_co} + {co[COEF_BITS-1], co};
  always_comb begin
    if (sum_w[COEF_BITS] != sum_w[COEF_BITS-1]) begin
      sat = sum_w[COEF_BITS] ? CoefMin : CoefMax;
    end else begin
      sat = sum_w[COEF_BITS-1:0];
    end
  end

  // Shift source of each entry: its upper neighbour
  always_comb begin
    for (int k = 0; k < MAX_TERMS; k++) begin
      sh_ex[k] = ex_m[(k == 0) ? 0 : k - 1];
      sh_co[k] = co_m[(k == 0) ? 0 : k - 1];
    end
  end

  // Combine, or shift the tail down and insert
  always_ff @(posedge clk) begin
    if (insert) begin
      for (int k = 0; k < MAX_TERMS; k++) begin
        if (hit) begin
          if (CNT_W'(k) == rd_idx) begin
            co_m[k] <= sat;
          end
        end else if (!full) begin
          if (CNT_W'(k) == rd_idx) begin
            ex_m[k] <= ex;
            co_m[k] <= co;
          end else if ((CNT_W'(k) > rd_idx) && (CNT_W'(k) <= cnt)) begin
            ex_m[k] <= sh_ex[k];
            co_m[k] <= sh_co[k];
          end
        end
      end
    end
  end

  // Fill count
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      cnt <= '0;
    end else if (insert && !hit && !full) begin
      cnt <= cnt + CNT_W'(1);
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/spa_datapath.sv =====
// ----------------------------------------------------------------------------
// spa_datapath - stores, read indexes, merge logic and output register
// Latches the input transaction, walks the selected store for the insert
// position, merges both stores one sum term per step into the output
// register that drives the master-side stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spa_datapath #(
  parameter int unsigned MAX_TERMS = spa_pkg::MaxTermsDef,
  parameter int unsigned EXP_BITS  = spa_pkg::ExpBitsDef,
  parameter int unsigned COEF_BITS = spa_pkg::CoefBitsDef,
  localparam int unsigned IN_W     = ((EXP_BITS + COEF_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_W    = ((EXP_BITS + COEF_BITS + 1 + 7) / 8) * 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire spa_pkg::cmd_t    cmd,
  output spa_pkg::sts_t         sts,
  input  wire logic [IN_W-1:0]  s_tdata,
  input  wire spa_pkg::op_t     s_tuser,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic [OUT_W-1:0]      m_tdata,
  output logic                  m_tuser,
  output logic                  m_tlast
);

  import spa_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_TERMS + 1);

  op_t                         op_q;
  logic [EXP_BITS-1:0]         ex_q;
  logic signed [COEF_BITS-1:0] co_q;
  logic [CNT_W-1:0]            i;
  logic [CNT_W-1:0]            j;
  logic [CNT_W-1:0]            i_next;
  logic [CNT_W-1:0]            j_next;
  logic [CNT_W-1:0]            cnt_a;
  logic [CNT_W-1:0]            cnt_b;
  logic [EXP_BITS-1:0]         a_ex;
  logic [EXP_BITS-1:0]         b_ex;
  logic signed [COEF_BITS-1:0] a_co;
  logic signed [COEF_BITS-1:0] b_co;
  logic                        sel_b;
  logic                        a_ok;
  logic                        b_ok;
  logic                        use_a;
  logic                        use_b;
  logic signed [COEF_BITS:0]   term_a;
  logic signed [COEF_BITS:0]   term_b;
  logic signed [COEF_BITS:0]   sum_co;
  logic [EXP_BITS-1:0]         out_ex;
  logic signed [COEF_BITS:0]   out_co;
  logic                        out_term;
  logic                        out_last;

  assign sel_b = (op_q == OP_LOAD_B);

  spa_store #(
    .MAX_TERMS (MAX_TERMS),
    .EXP_BITS  (EXP_BITS),
    .COEF_BITS (COEF_BITS)
  ) u_store_a (
    .clk    (clk),
    .rst    (rst),
    .clear  (cmd.clear),
    .insert (cmd.insert && !sel_b),
    .ex     (ex_q),
    .co     (co_q),
    .rd_idx (i),
    .rd_ex  (a_ex),
    .rd_co  (a_co),
    .cnt    (cnt_a)
  );

  spa_store #(
    .MAX_TERMS (MAX_TERMS),
    .EXP_BITS  (EXP_BITS),
    .COEF_BITS (COEF_BITS)
  ) u_store_b (
    .clk    (clk),
    .rst    (rst),
    .clear  (cmd.clear),
    .insert (cmd.insert && sel_b),
    .ex     (ex_q),
    .co     (co_q),
    .rd_idx (j),
    .rd_ex  (b_ex),
    .rd_co  (b_co),
    .cnt    (cnt_b)
  );

  // Latch the input transaction
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q <= s_tuser;
      ex_q <= s_tdata[EXP_BITS-1:0];
      co_q <= s_tdata[EXP_BITS +: COEF_BITS];
    end
  end

  // Merge step: pick the larger exponent, add on a tie
  assign a_ok  = (i < cnt_a);
  assign b_ok  = (j < cnt_b);
  assign use_a = a_ok && (!b_ok || (a_ex >= b_ex));
  assign use_b = b_ok && (!a_ok || (b_ex >= a_ex));

  assign term_a = use_a ? {a_co[COEF_BITS-1], a_co} : '0;
  assign term_b = use_b ? {b_co[COEF_BITS-1], b_co} : '0;
  assign sum_co = term_a + term_b;

  assign i_next = i + CNT_W'(use_a);
  assign j_next = j + CNT_W'(use_b);

  // Read indexes: insert position while loading, merge cursors on emit
  always_ff @(posedge clk) begin
    if (rst || cmd.capture) begin
      i <= '0;
      j <= '0;
    end else if (cmd.search_step) begin
      if (sel_b) begin
        j <= j + CNT_W'(1);
      end else begin
        i <= i + CNT_W'(1);
      end
    end else if (cmd.merge_emit) begin
      i <= i_next;
      j <= j_next;
    end
  end

  // Status
  always_comb begin
    sts.search_done = sel_b ? (!b_ok || (b_ex <= ex_q)) : (!a_ok || (a_ex <= ex_q));
    sts.merge_last  = (i_next >= cnt_a) && (j_next >= cnt_b);
    sts.sum_empty   = (cnt_a == '0) && (cnt_b == '0);
    sts.out_free    = !m_tvalid || m_tready;
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (cmd.merge_emit) begin
      out_ex   <= use_a ? a_ex : b_ex;
      out_co   <= sum_co;
      out_term <= 1'b1;
      out_last <= sts.merge_last;
    end else if (cmd.empty_emit) begin
      out_ex   <= '0;
      out_co   <= '0;
      out_term <= 1'b0;
      out_last <= 1'b1;
    end
  end

  // Output register valid: set on load, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.merge_emit || cmd.empty_emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = OUT_W'({out_co, out_ex});
  assign m_tuser = out_term;
  assign m_tlast = out_last;

  // Checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    (cnt_a <= CNT_W'(MAX_TERMS)) && (cnt_b <= CNT_W'(MAX_TERMS)))
    else $error("store fill count beyond capacity");

  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    (i <= cnt_a) && (j <= cnt_b))
    else $error("read index beyond fill count");

  a_emit_slot: assert property (@(posedge clk) disable iff (rst)
    (cmd.merge_emit || cmd.empty_emit) |-> (!m_tvalid || m_tready))
    else $error("output register loaded while a result waits");

endmodule

`default_nettype wire

// ===== hw/rtl/spa_ctrl.sv =====
// ----------------------------------------------------------------------------
// spa_ctrl - sequencing state machine
// Accepts one transaction at a time, walks the insert search of a load,
// and paces the merge of an emit against the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spa_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire spa_pkg::op_t  s_tuser,
  input  wire spa_pkg::sts_t sts,
  output spa_pkg::cmd_t      cmd
);

  import spa_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          case (s_tuser)
            OP_LOAD_A, OP_LOAD_B: state_next = ST_SEARCH;
            OP_EMIT:              state_next = ST_MERGE;
            OP_CLEAR:             cmd.clear  = 1'b1;
            default:              state_next = ST_IDLE;
          endcase
        end
      end
      ST_SEARCH: begin
        if (sts.search_done) begin
          state_next = ST_INSERT;
        end else begin
          cmd.search_step = 1'b1;
        end
      end
      ST_INSERT: begin
        cmd.insert = 1'b1;
        state_next = ST_IDLE;
      end
      ST_MERGE: begin
        if (sts.out_free) begin
          if (sts.sum_empty) begin
            cmd.empty_emit = 1'b1;
            state_next     = ST_IDLE;
          end else begin
            cmd.merge_emit = 1'b1;
            if (sts.merge_last) begin
              state_next = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Checks
  a_search_exit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEARCH) |=> (state == ST_SEARCH) || (state == ST_INSERT))
    else $error("search left without insert");

  a_insert_once: assert property (@(posedge clk) disable iff (rst)
    (state == ST_INSERT) |=> (state == ST_IDLE))
    else $error("insert held for more than one cycle");

  a_emit_entry: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && (s_tuser == OP_EMIT)) |=> (state == ST_MERGE))
    else $error("emit transaction did not start a merge");

endmodule

`default_nettype wire

// ===== hw/rtl/sparse_polynomial_adder_top.sv =====
// ----------------------------------------------------------------------------
// sparse_polynomial_adder_top - sparse polynomial addition by sorted merge
// Loads terms into two stores kept in descending exponent order, combining
// equal exponents with saturation, and on emit streams the merged sum.
//
//   channel  dir  handshake          tdata (low bit up)              tuser
//   s_*      in   s_tvalid/s_tready  exponent, coefficient           operation
//   m_*      out  m_tvalid/m_tready  sum_exponent, sum_coefficient   term_valid
//                                    (m_tlast carries last_term)
//
// A load holds s_tready low after its transaction while the insert search reads
// the stored terms with a larger exponent, one store entry per cycle, and then
// while the insert state combines or inserts. An emit holds s_tready low until
// its last result is loaded, count_a + count_b results at most or the one
// empty-sum result, and longer while the output register is stalled; a clear
// leaves it high. One transaction is worked at a time; the next is accepted once
// the controller is idle, even while the final result still waits in m_tdata.
// rst clears the fill counts, indexes, state and output valid; store contents
// are only read below the fill count and need no clearing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sparse_polynomial_adder_top #(
  parameter int unsigned MAX_TERMS = spa_pkg::MaxTermsDef,
  parameter int unsigned EXP_BITS  = spa_pkg::ExpBitsDef,
  parameter int unsigned COEF_BITS = spa_pkg::CoefBitsDef,
  localparam int unsigned IN_W     = ((EXP_BITS + COEF_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_W    = ((EXP_BITS + COEF_BITS + 1 + 7) / 8) * 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [IN_W-1:0]  s_tdata,   // exponent, coefficient
  input  wire spa_pkg::op_t     s_tuser,   // operation
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic [OUT_W-1:0]      m_tdata,   // sum_exponent, sum_coefficient
  output logic                  m_tuser,   // term_valid
  output logic                  m_tlast    // last_term
);

  import spa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  spa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .sts      (sts),
    .cmd      (cmd)
  );

  spa_datapath #(
    .MAX_TERMS (MAX_TERMS),
    .EXP_BITS  (EXP_BITS),
    .COEF_BITS (COEF_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire

// ===== dv/sparse_polynomial_adder_checker.sv =====
// ----------------------------------------------------------------------------
// sparse_polynomial_adder_checker - result checker for the polynomial adder
// Watches both stream channels. Every accepted load or clear transaction updates a
// private copy of the two term stores; every emit queues the merged sum terms
// it should produce. Each accepted output transaction is compared field by
// field with the oldest queued term.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sparse_polynomial_adder_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [23:0]  s_tdata,   // exponent, coefficient
  input  spa_pkg::op_t s_tuser,   // operation
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [31:0]  m_tdata,   // sum_exponent, sum_coefficient
  input  logic         m_tuser,   // term_valid
  input  logic         m_tlast,   // last_term
  output int           mismatch_count,
  output int           terms_pending
);

  import spa_pkg::*;

  localparam int STORE_DEPTH = 16;
  localparam int COEF_MAX    = 32767;
  localparam int COEF_MIN    = -32768;
  localparam int STORE_A     = 0;
  localparam int STORE_B     = 1;

  typedef struct packed {
    logic [7:0]  ex;
    logic [16:0] co;
    logic        valid;
    logic        last;
  } sum_term_t;

  // Model of the two stores, index 0 for A and 1 for B
  logic [7:0]        store_ex [2][STORE_DEPTH];
  logic signed [15:0] store_co [2][STORE_DEPTH];
  int                store_fill [2];
  sum_term_t         merged_terms_due [$];

  initial begin
    mismatch_count = 0;
    terms_pending  = 0;
    store_fill[0]  = 0;
    store_fill[1]  = 0;
  end

  // Combine with an equal exponent, else insert in descending order
  task automatic fold_term_into_store(input int sel, input logic [7:0] ex,
                                      input logic signed [15:0] co);
    int pos;
    int k;
    int total;
    pos = 0;
    while (pos < store_fill[sel] && store_ex[sel][pos] > ex) pos++;
    if (pos < store_fill[sel] && store_ex[sel][pos] == ex) begin
      total = int'(store_co[sel][pos]) + int'(co);
      if (total > COEF_MAX) total = COEF_MAX;
      if (total < COEF_MIN) total = COEF_MIN;
      store_co[sel][pos] = 16'(total);
    end else if (store_fill[sel] < STORE_DEPTH) begin
      for (k = store_fill[sel]; k > pos; k--) begin
        store_ex[sel][k] = store_ex[sel][k-1];
        store_co[sel][k] = store_co[sel][k-1];
      end
      store_ex[sel][pos] = ex;
      store_co[sel][pos] = co;
      store_fill[sel]++;
    end
  endtask

  // Merge both stores into the queue of expected sum terms
  task automatic predict_merged_sum();
    int i;
    int j;
    int total;
    sum_term_t t;
    i = 0;
    j = 0;
    if (store_fill[STORE_A] == 0 && store_fill[STORE_B] == 0) begin
      t = '{ex: 8'd0, co: 17'd0, valid: 1'b0, last: 1'b1};
      merged_terms_due.push_back(t);
    end
    while (i < store_fill[STORE_A] || j < store_fill[STORE_B]) begin
      if (i < store_fill[STORE_A] && j < store_fill[STORE_B] &&
          store_ex[STORE_A][i] == store_ex[STORE_B][j]) begin
        total = int'(store_co[STORE_A][i]) + int'(store_co[STORE_B][j]);
        t.ex  = store_ex[STORE_A][i];
        i++;
        j++;
      end else if (j >= store_fill[STORE_B] ||
                   (i < store_fill[STORE_A] &&
                    store_ex[STORE_A][i] > store_ex[STORE_B][j])) begin
        total = int'(store_co[STORE_A][i]);
        t.ex  = store_ex[STORE_A][i];
        i++;
      end else begin
        total = int'(store_co[STORE_B][j]);
        t.ex  = store_ex[STORE_B][j];
        j++;
      end
      t.co    = 17'(total);
      t.valid = 1'b1;
      t.last  = (i >= store_fill[STORE_A] && j >= store_fill[STORE_B]);
      merged_terms_due.push_back(t);
    end
  endtask

  // Compare output transactions, then fold in the input transaction
  always @(posedge clk) begin
    sum_term_t got;
    sum_term_t want;
    if (rst) begin
      store_fill[STORE_A] = 0;
      store_fill[STORE_B] = 0;
      merged_terms_due.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got = '{ex: m_tdata[7:0], co: m_tdata[24:8], valid: m_tuser, last: m_tlast};
        if (merged_terms_due.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected sum term: expected none,", $time);
          $display("%0t:   actual exp=%0d coef=%0d valid=%0b last=%0b",
                   $time, got.ex, $signed(got.co), got.valid, got.last);
        end else begin
          want = merged_terms_due.pop_front();
          if (got.ex !== want.ex || got.co !== want.co ||
              got.valid !== want.valid || got.last !== want.last) begin
            mismatch_count++;
            $display("%0t: sum term mismatch: expected exp=%0d coef=%0d valid=%0b last=%0b",
                     $time, want.ex, $signed(want.co), want.valid, want.last);
            $display("%0t:                    actual   exp=%0d coef=%0d valid=%0b last=%0b",
                     $time, got.ex, $signed(got.co), got.valid, got.last);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        case (s_tuser)
          OP_LOAD_A: fold_term_into_store(STORE_A, s_tdata[7:0], s_tdata[23:8]);
          OP_LOAD_B: fold_term_into_store(STORE_B, s_tdata[7:0], s_tdata[23:8]);
          OP_EMIT:   predict_merged_sum();
          OP_CLEAR: begin
            store_fill[STORE_A] = 0;
            store_fill[STORE_B] = 0;
          end
          default: ;
        endcase
      end
    end
    terms_pending = merged_terms_due.size();
  end

endmodule

// ===== dv/sparse_polynomial_adder_top_test.sv =====
// ----------------------------------------------------------------------------
// sparse_polynomial_adder_top_test - stimulus and verdict for the adder
// Drives load, emit and clear transactions: a directed run over coefficient
// saturation, cancelling sums and empty sums, then random rounds of loads
// closed by an emit, store overfills and loose noise. Both channels stall in
// random bursts, and the receiver holds off once for a long stretch so the
// block backs up onto its input. The checker beside the block does the
// comparison and reports its mismatch count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sparse_polynomial_adder_top_test;
  import spa_pkg::*;

  localparam int RANDOM_ITEMS = 120;
  localparam int CALM_AFTER   = 95;
  localparam int HOLD_CYCLES  = 400;
  localparam int QUIET_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 50;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;   // exponent, coefficient
  op_t         s_tuser;   // operation
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // sum_exponent, sum_coefficient
  logic        m_tuser;   // term_valid
  logic        m_tlast;   // last_term

  int mismatch_count;
  int terms_pending;
  int items_sent;
  int quiet_cycles;
  bit calm;
  bit hold_now;

  sparse_polynomial_adder_top DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  sparse_polynomial_adder_checker sum_checker (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tuser        (m_tuser),
    .m_tlast        (m_tlast),
    .mismatch_count (mismatch_count),
    .terms_pending  (terms_pending)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Abort when no transaction moves for too long
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One stretch of ready or stall; always ready once the run is calm
  task automatic receiver_burst();
    if (calm) begin
      m_tready <= 1'b1;
      @(negedge clk);
    end else if ($urandom_range(0, 2) == 0) begin
      m_tready <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end else begin
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
  endtask

  // Receiver, with one long hold-off while the sender keeps offering
  initial begin
    wait (!rst);
    @(negedge clk);
    while (!hold_now) receiver_burst();
    m_tready <= 1'b0;
    repeat (HOLD_CYCLES) @(negedge clk);
    forever receiver_burst();
  end

  // Offer one transaction and hold it until accepted
  task automatic send_item(input op_t op, input logic [7:0] ex, input logic [15:0] co);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {co, ex};
    s_tuser  <= op;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic load_term(input bit to_b, input logic [7:0] ex, input logic [15:0] co);
    send_item(to_b ? OP_LOAD_B : OP_LOAD_A, ex, co);
  endtask

  // Mostly random coefficients, with the extremes now and then
  function automatic logic [15:0] pick_coef();
    case ($urandom_range(0, 7))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Stimulus
  initial begin
    int kind;
    int n;
    int k;
    bit sel;
    logic [7:0] exp_top;
    logic [7:0] base;
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tuser    = OP_LOAD_A;
    m_tready   = 1'b0;
    calm       = 1'b0;
    hold_now   = 1'b0;
    items_sent = 0;
    quiet_cycles = 0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty sum, saturation both ways, cancelling terms
    send_item(OP_EMIT, 8'd0, 16'h0000);
    load_term(1'b0, 8'd255, 16'h7fff);
    load_term(1'b0, 8'd255, 16'h0001);
    load_term(1'b0, 8'd0, 16'h8000);
    load_term(1'b0, 8'd0, 16'hffff);
    load_term(1'b1, 8'd255, 16'h7fff);
    load_term(1'b1, 8'd0, 16'h8000);
    load_term(1'b1, 8'd100, 16'd5);
    load_term(1'b0, 8'd100, 16'hfffb);
    load_term(1'b0, 8'd50, 16'd3);
    load_term(1'b0, 8'd50, 16'hfffd);
    load_term(1'b1, 8'haa, 16'haaaa);
    load_term(1'b0, 8'h55, 16'h5555);
    // Long receiver hold-off starts with a multi-term emit in flight
    hold_now = 1'b1;
    send_item(OP_EMIT, 8'd0, 16'h0000);
    load_term(1'b1, 8'd1, 16'd1);
    send_item(OP_CLEAR, 8'hff, 16'hffff);
    send_item(OP_EMIT, 8'd0, 16'h0000);
    load_term(1'b1, 8'd7, 16'd1);
    send_item(OP_EMIT, 8'd0, 16'h0000);
    load_term(1'b0, 8'd9, 16'd2);
    send_item(OP_EMIT, 8'd0, 16'h0000);

    // Random rounds, until the whole run reaches its item count
    while (items_sent < RANDOM_ITEMS) begin
      calm = (items_sent >= CALM_AFTER);
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        // Well-formed: optional clear, loads, emit
        if ($urandom_range(0, 2) != 0) send_item(OP_CLEAR, 8'($urandom), 16'($urandom));
        exp_top = $urandom_range(0, 1) ? 8'd15 : 8'd255;
        n = $urandom_range(1, 10);
        repeat (n) load_term(1'($urandom), 8'($urandom_range(0, exp_top)), pick_coef());
        send_item(OP_EMIT, 8'($urandom), 16'($urandom));
      end else if (kind == 7) begin
        // Overfill one store with distinct exponents in shuffled order
        send_item(OP_CLEAR, 8'($urandom), 16'($urandom));
        sel  = 1'($urandom);
        base = 8'($urandom_range(0, 34));
        for (k = 0; k < 18; k++) load_term(sel, 8'(base + ((k * 7) % 18) * 13), pick_coef());
        repeat (3) load_term(!sel, 8'($urandom), pick_coef());
        send_item(OP_EMIT, 8'($urandom), 16'($urandom));
      end else begin
        // Loose noise
        repeat ($urandom_range(2, 6)) send_item(op_t'($urandom_range(0, 3)), 8'($urandom),
                                                16'($urandom));
      end
    end
    calm = 1'b1;
    s_tvalid <= 1'b0;

    // Drain and give the verdict
    while (terms_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
